@@ sv/rbb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the RGB box blur: configuration indexes, register widths and defaults.
// Depends on nothing; used by every module of the block.
package rbb_pkg;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_RADIUS = 12;

  localparam int RADIUS_REG_W = 4;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int PIX_W        = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [RADIUS_REG_W-1:0] RADIUS_RESET = 4'd1;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd4096;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

@@ sv/rbb_line_ram.sv @@
`timescale 1ns / 1ps
// Line store ring: one write port, one registered read port.
// Depends on rbb_pkg for the pixel width.
module rbb_line_ram #(
  parameter int DEPTH  = 53248,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [rbb_pkg::PIX_W-1:0] wr_data,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [rbb_pkg::PIX_W-1:0] rd_data
);
  import rbb_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ sv/rbb_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, three lanes sharing one divisor, one quotient bit per cycle.
// Depends on rbb_pkg for the control struct.
module rbb_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rbb_pkg::div_ctl_t         ctl_in,
  output rbb_pkg::div_ctl_t         ctl_out,
  input  logic [2:0][NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]          den,
  output logic [2:0][NUM_W-1:0]     quo
);
  import rbb_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [2:0][DEN_W:0] rem;
  logic [DEN_W-1:0]    d;
  logic [STEP_W-1:0]   steps;
  logic                busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (ctl_in.start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(NUM_W);
      d     <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      for (int i = 0; i < 3; i++) begin
        if ({rem[i][DEN_W-1:0], quo[i][NUM_W-1]} >= {1'b0, d}) begin
          rem[i] <= {rem[i][DEN_W-1:0], quo[i][NUM_W-1]} - {1'b0, d};
          quo[i] <= {quo[i][NUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= {rem[i][DEN_W-1:0], quo[i][NUM_W-1]};
          quo[i] <= {quo[i][NUM_W-2:0], 1'b0};
        end
      end
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.busy  = busy | ctl_in.start;
endmodule

@@ sv/rgb_box_blur_edge_normalized.sv @@
`timescale 1ns / 1ps
// Top level of the RGB box blur with an edge-normalized shrinking window.
// Depends on rbb_pkg, rbb_line_ram and rbb_div.
//
// Pixels enter in raster order on the s_ side and are written into a ring of
// 2*MAX_RADIUS+2 rows of MAX_WIDTH pixels held in one synchronous memory.
// After each input beat the block checks whether the window of the next
// result lies fully inside the rows received; if so it reads the window from
// the memory one pixel per cycle, sums R, G and B, reads the center pixel for
// alpha, and divides each sum by the pixel count with a shared bit-serial
// divider. An input beat that yields no result goes from S_CHECK back to
// S_IDLE; one that does goes through S_SUM, S_CENTER, S_LOAD, S_DIV and S_OUT,
// and waits in S_OUT while the previous result still waits on m_tready.
// s_tready is low outside S_IDLE, so no new beat is taken before the last one
// is through; the memory read port sets the length of S_SUM. A beat with tuser
// high carries no pixel and only lets a pending result out, which is how the
// last rows are drained after a frame. Pixels arriving after the last pixel of a
// frame, before its final result has left, are dropped. Writing the width or
// height register restarts the frame. The line store has no reset clear.
module rgb_box_blur_edge_normalized #(
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = rbb_pkg::DEF_MAX_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: in_red, in_green, in_blue, in_alpha (from bit 0 up)
  input  logic [rbb_pkg::PIX_W-1:0]      s_tdata,
  // s_tuser: tick_only
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: out_red, out_green, out_blue, out_alpha (from bit 0 up)
  output logic [rbb_pkg::PIX_W-1:0]      m_tdata,
  // m_tlast: frame_end
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbb_pkg::*;

  localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int RING_W    = $clog2(RING_ROWS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int R_W       = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W     = CNT_W + 8;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_CENTER = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state;

  // Configuration registers, raw as written.
  logic [RADIUS_REG_W-1:0] blur_radius;
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;

  // Positions of the next input pixel and the next result.
  logic [COL_W-1:0]  in_col, out_col, x0, x1, xc;
  logic [ROW_W-1:0]  in_row, out_row, y1, yc;
  logic [RING_W-1:0] in_ring, out_ring, yring;
  logic              draining;

  // Window accumulation.
  logic                  acc_en;
  logic [2:0][SUM_W-1:0] sums;
  logic [CNT_W-1:0]      count;
  logic [7:0]            alpha;
  logic                  last_px;

  // Effective (clamped) settings.
  logic [R_W-1:0]   r;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  always_comb begin
    if (blur_radius == '0) begin
      r = R_W'(1);
    end else if (int'(blur_radius) > MAX_RADIUS) begin
      r = R_W'(MAX_RADIUS);
    end else begin
      r = R_W'(blur_radius);
    end
    if (frame_width == '0) begin
      w_last = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(frame_height - 1'b1);
    end
  end

  // Window bounds of the next result, clipped to the frame.
  logic [ROW_W:0]    row_hi;
  logic [COL_W:0]    col_hi;
  logic [ROW_W-1:0]  y0_c;
  logic [COL_W-1:0]  x0_c;
  logic [RING_W-1:0] y0_ring;
  logic              win_ready;

  always_comb begin
    row_hi = {1'b0, out_row} + (ROW_W + 1)'(r);
    if (row_hi > {1'b0, h_last}) row_hi = {1'b0, h_last};
    col_hi = {1'b0, out_col} + (COL_W + 1)'(r);
    if (col_hi > {1'b0, w_last}) col_hi = {1'b0, w_last};
    win_ready = draining || ({1'b0, in_row} > row_hi) ||
                (({1'b0, in_row} == row_hi) && ({1'b0, in_col} > col_hi));
    if (int'(out_row) >= int'(r)) begin
      y0_c = out_row - ROW_W'(r);
      if (int'(out_ring) >= int'(r)) begin
        y0_ring = out_ring - RING_W'(r);
      end else begin
        y0_ring = RING_W'(int'(out_ring) + RING_ROWS - int'(r));
      end
    end else begin
      y0_c    = '0;
      y0_ring = '0;
    end
    if (int'(out_col) >= int'(r)) begin
      x0_c = out_col - COL_W'(r);
    end else begin
      x0_c = '0;
    end
  end

  // Line store.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              in_beat, out_beat, pix_write;

  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign out_beat  = m_tvalid && m_tready;
  assign pix_write = in_beat && !s_tuser && !draining;
  assign ram_we    = pix_write;
  assign wr_addr   = ADDR_W'(in_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign ram_re    = (state == S_SUM) || (state == S_CENTER);

  always_comb begin
    if (state == S_CENTER) begin
      rd_addr = ADDR_W'(out_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col);
    end else begin
      rd_addr = ADDR_W'(yring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xc);
    end
  end

  rbb_line_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (s_tdata),
    .re      (ram_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Divider.
  div_ctl_t              div_in, div_out;
  logic [2:0][SUM_W-1:0] quo;

  assign div_in.start = (state == S_LOAD);
  assign div_in.busy  = 1'b0;

  rbb_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (div_in),
    .ctl_out (div_out),
    .num     (sums),
    .den     (count),
    .quo     (quo)
  );

  // Sum accumulation; data arrives in the cycle after each window read.
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      sums  <= '0;
      count <= '0;
    end else if (acc_en) begin
      sums[0] <= sums[0] + SUM_W'(rd_data[7:0]);
      sums[1] <= sums[1] + SUM_W'(rd_data[15:8]);
      sums[2] <= sums[2] + SUM_W'(rd_data[23:16]);
      count   <= count + 1'b1;
    end
    if (state == S_LOAD) begin
      alpha <= rd_data[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      blur_radius  <= RADIUS_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      in_ring      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_ring     <= '0;
      draining     <= 1'b0;
      acc_en       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_beat) begin
        m_tvalid <= 1'b0;
      end
      acc_en <= (state == S_SUM);

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= S_CHECK;
          end
          if (pix_write) begin
            if (in_col >= w_last) begin
              in_col <= '0;
              if (in_row >= h_last) begin
                in_row   <= '0;
                in_ring  <= '0;
                draining <= 1'b1;
              end else begin
                in_row  <= in_row + 1'b1;
                in_ring <= (int'(in_ring) == RING_ROWS - 1) ? '0 : in_ring + 1'b1;
              end
            end else begin
              in_col <= in_col + 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (win_ready) begin
            yc    <= y0_c;
            yring <= y0_ring;
            xc    <= x0_c;
            x0    <= x0_c;
            x1    <= COL_W'(col_hi);
            y1    <= ROW_W'(row_hi);
            state <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          if (xc == x1) begin
            xc <= x0;
            if (yc == y1) begin
              state <= S_CENTER;
            end else begin
              yc    <= yc + 1'b1;
              yring <= (int'(yring) == RING_ROWS - 1) ? '0 : yring + 1'b1;
            end
          end else begin
            xc <= xc + 1'b1;
          end
        end
        S_CENTER: begin
          last_px <= (out_col == w_last) && (out_row == h_last);
          state   <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_out.busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || out_beat) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {alpha, quo[2][7:0], quo[1][7:0], quo[0][7:0]};
            m_tlast  <= last_px;
            state    <= S_IDLE;
            if (last_px) begin
              out_col  <= '0;
              out_row  <= '0;
              out_ring <= '0;
              draining <= 1'b0;
            end else if (out_col >= w_last) begin
              out_col  <= '0;
              out_row  <= out_row + 1'b1;
              out_ring <= (int'(out_ring) == RING_ROWS - 1) ? '0 : out_ring + 1'b1;
            end else begin
              out_col <= out_col + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // The user must write configuration only while idle (not enforced); size writes restart the frame.
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS: blur_radius <= cfg_data[RADIUS_REG_W-1:0];
          REG_WIDTH, REG_HEIGHT: begin
            if (cfg_index == REG_WIDTH) begin
              frame_width <= cfg_data[WIDTH_REG_W-1:0];
            end else begin
              frame_height <= cfg_data[HEIGHT_REG_W-1:0];
            end
            in_col   <= '0;
            in_row   <= '0;
            in_ring  <= '0;
            out_col  <= '0;
            out_row  <= '0;
            out_ring <= '0;
            draining <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

@@ sv/rbb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the box blur, bound to the top level.
// Depends on rbb_pkg and rgb_box_blur_edge_normalized.
module rbb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rbb_pkg::PIX_W-1:0] m_tdata,
  input logic                      m_tlast
);
  import rbb_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result payload changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");
endmodule

bind rgb_box_blur_edge_normalized rbb_checker u_rbb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
